[rtl/core/qvr_pkg.sv]
// Shared widths, register codes and beat types of the quaternion vector rotator.
package qvr_pkg;

  localparam int QVR_VEC_WIDTH  = 16;
  localparam int QVR_QUAT_WIDTH = 16;
  localparam int QVR_FRAC_BITS  = 14;
  localparam int QVR_PROD_WIDTH = 2 * QVR_QUAT_WIDTH;
  // Off-diagonal entries are twice a sum or difference of two products.
  localparam int QVR_MAT_WIDTH  = 2 * QVR_QUAT_WIDTH + 2;
  // Matrix entries are multiplied as a signed upper half and an unsigned lower half.
  localparam int QVR_SPLIT      = QVR_MAT_WIDTH / 2;
  localparam int QVR_IDX_WIDTH  = 2;

  typedef enum logic [QVR_IDX_WIDTH-1:0] {
    REG_QUAT_W,
    REG_QUAT_X,
    REG_QUAT_Y,
    REG_QUAT_Z
  } qvr_reg_t;

  typedef logic signed [QVR_MAT_WIDTH-1:0] qvr_entry_t;

  typedef struct packed {
    logic signed [QVR_VEC_WIDTH-1:0] vec_x;
    logic signed [QVR_VEC_WIDTH-1:0] vec_y;
    logic signed [QVR_VEC_WIDTH-1:0] vec_z;
  } qvr_vec_t;

  typedef struct packed {
    logic signed [QVR_VEC_WIDTH-1:0] rot_x;
    logic signed [QVR_VEC_WIDTH-1:0] rot_y;
    logic signed [QVR_VEC_WIDTH-1:0] rot_z;
    logic                            clipped;
  } qvr_rot_t;

endpackage

[rtl/core/qvr_matrix.sv]
// Quaternion registers and the rotation matrix derived from them in two stages.
module qvr_matrix
  import qvr_pkg::*;
#(
  parameter int FRAC_BITS = QVR_FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [QVR_IDX_WIDTH-1:0] cfg_index,
  input  logic [QVR_QUAT_WIDTH-1:0] cfg_data,
  output qvr_entry_t               mat [3][3]
);

  localparam int MW = QVR_MAT_WIDTH;

  logic signed [QVR_QUAT_WIDTH-1:0] quat_w, quat_x, quat_y, quat_z;
  logic signed [QVR_PROD_WIDTH-1:0] ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      quat_w <= QVR_QUAT_WIDTH'(1 << FRAC_BITS);
      quat_x <= '0;
      quat_y <= '0;
      quat_z <= '0;
    end else if (cfg_valid) begin
      case (qvr_reg_t'(cfg_index))
        REG_QUAT_W: quat_w <= cfg_data;
        REG_QUAT_X: quat_x <= cfg_data;
        REG_QUAT_Y: quat_y <= cfg_data;
        REG_QUAT_Z: quat_z <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    ww <= quat_w * quat_w;
    xx <= quat_x * quat_x;
    yy <= quat_y * quat_y;
    zz <= quat_z * quat_z;
    xy <= quat_x * quat_y;
    xz <= quat_x * quat_z;
    yz <= quat_y * quat_z;
    wx <= quat_w * quat_x;
    wy <= quat_w * quat_y;
    wz <= quat_w * quat_z;
  end

  always_ff @(posedge clk) begin
    mat[0][0] <= MW'(ww) + MW'(xx) - MW'(yy) - MW'(zz);
    mat[0][1] <= (MW'(xy) - MW'(wz)) <<< 1;
    mat[0][2] <= (MW'(xz) + MW'(wy)) <<< 1;
    mat[1][0] <= (MW'(xy) + MW'(wz)) <<< 1;
    mat[1][1] <= MW'(ww) - MW'(xx) + MW'(yy) - MW'(zz);
    mat[1][2] <= (MW'(yz) - MW'(wx)) <<< 1;
    mat[2][0] <= (MW'(xz) - MW'(wy)) <<< 1;
    mat[2][1] <= (MW'(yz) + MW'(wx)) <<< 1;
    mat[2][2] <= MW'(ww) - MW'(xx) - MW'(yy) + MW'(zz);
  end

endmodule

[rtl/core/qvr_datapath.sv]
// Six-stage vector pipeline: matrix multiply, rounding and saturation.
module qvr_datapath
  import qvr_pkg::*;
#(
  parameter int FRAC_BITS = QVR_FRAC_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       vec_valid,
  output logic       vec_stall,
  input  qvr_vec_t   vec,
  output logic       rot_valid,
  input  logic       rot_stall,
  output qvr_rot_t   rot,
  input  qvr_entry_t mat [3][3]
);

  localparam int VW    = QVR_VEC_WIDTH;
  localparam int MW    = QVR_MAT_WIDTH;
  localparam int SPLIT = QVR_SPLIT;
  localparam int PH_W  = MW - SPLIT + VW;
  localparam int PL_W  = SPLIT + 1 + VW;
  localparam int EW    = MW + VW;
  localparam int SW    = EW + 2;
  localparam int SHIFT = 2 * FRAC_BITS;
  localparam int SUM_W = ((SW > SHIFT + 1) ? SW : SHIFT + 1) + 1;

  localparam logic signed [SUM_W-1:0] RND   = SUM_W'(1) << (SHIFT - 1);
  localparam logic signed [SUM_W-1:0] HI    = {{(SUM_W-VW+1){1'b0}}, {(VW-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] LO    = {{(SUM_W-VW+1){1'b1}}, {(VW-1){1'b0}}};
  localparam logic signed [VW-1:0]    V_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0]    V_MIN = {1'b1, {(VW-1){1'b0}}};

  logic [6:1] vld;
  logic [6:1] rdy;

  qvr_vec_t s1_vec, s2_vec;
  logic signed [VW-1:0]    vin [3];
  logic signed [PH_W-1:0]  ph_next [3][3];
  logic signed [PL_W-1:0]  pl_next [3][3];
  logic signed [PH_W-1:0]  ph [3][3];
  logic signed [PL_W-1:0]  pl [3][3];
  logic signed [EW-1:0]    elem [3][3];
  logic signed [SUM_W-1:0] acc [3];
  logic signed [SUM_W-1:0] rnd_val [3];
  logic signed [VW-1:0]    res [3];
  logic [2:0]              clip;
  qvr_rot_t                rot_next;

  // A stage moves on when it is empty or its successor moves on, so bubbles close up.
  always_comb begin
    rdy[6] = !vld[6] || !rot_stall;
    for (int k = 5; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign vec_stall = rst || !rdy[1];
  assign rot_valid = vld[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) vld[1] <= vec_valid;
      for (int k = 2; k <= 6; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign vin[0] = s2_vec.vec_x;
  assign vin[1] = s2_vec.vec_y;
  assign vin[2] = s2_vec.vec_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        ph_next[i][j] = PH_W'($signed(mat[i][j][MW-1:SPLIT])) * PH_W'(vin[j]);
        pl_next[i][j] = PL_W'($signed({1'b0, mat[i][j][SPLIT-1:0]})) * PL_W'(vin[j]);
      end
    end
  end

  // Round to nearest with ties upward, then clamp to the output range.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd_val[i] = acc[i] >>> SHIFT;
      if (rnd_val[i] > HI) begin
        res[i]  = V_MAX;
        clip[i] = 1'b1;
      end else if (rnd_val[i] < LO) begin
        res[i]  = V_MIN;
        clip[i] = 1'b1;
      end else begin
        res[i]  = rnd_val[i][VW-1:0];
        clip[i] = 1'b0;
      end
    end
    rot_next.rot_x   = res[0];
    rot_next.rot_y   = res[1];
    rot_next.rot_z   = res[2];
    rot_next.clipped = |clip;
  end

  // The second stage only delays the beat, so the multiply stage sees a matrix that
  // has settled after a configuration write made just before the beat arrived.
  always_ff @(posedge clk) begin
    if (rdy[1]) s1_vec <= vec;
    if (rdy[2]) s2_vec <= s1_vec;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (rdy[3]) begin
          ph[i][j] <= ph_next[i][j];
          pl[i][j] <= pl_next[i][j];
        end
        if (rdy[4]) elem[i][j] <= (EW'(ph[i][j]) <<< SPLIT) + EW'(pl[i][j]);
      end
      if (rdy[5]) acc[i] <= SUM_W'(elem[i][0]) + SUM_W'(elem[i][1])
                            + SUM_W'(elem[i][2]) + RND;
    end
    if (rdy[6]) rot <= rot_next;
  end

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    vec_valid && !vec_stall |=> vld[1])
    else $error("accepted beat did not enter the first stage");

  a_stage5_holds: assert property (@(posedge clk) disable iff (rst)
    vld[5] && !rdy[6] |=> vld[5] && $stable(acc[0]) && $stable(acc[1]) && $stable(acc[2]))
    else $error("stalled row sums were lost or changed");

  a_clip_at_limit: assert property (@(posedge clk) disable iff (rst)
    rot_valid && rot.clipped |->
      rot.rot_x == V_MAX || rot.rot_x == V_MIN || rot.rot_y == V_MAX ||
      rot.rot_y == V_MIN || rot.rot_z == V_MAX || rot.rot_z == V_MIN)
    else $error("clipped flag set with no component at a limit");

endmodule

[rtl/core/quaternion_vector_rotate.sv]
// Top level of the quaternion vector rotator.
// Rotates each 16-bit signed vector by the configured Q2.14 quaternion q, returning
// the vector part of q*v*conj(q) rounded to nearest (ties upward) and saturated, with
// clipped set when any component hit a limit; a non-unit q also scales by |q|^2.
// One vector is accepted per cycle while vec_stall is low; each accepted beat passes
// through the six-stage pipeline (input, align, partial products, element sums, row
// sums, round and saturate); stalls on the result side only add delay, and empty
// stages are filled while a result waits. A register write takes effect for every
// vector accepted on a later cycle; the rotation matrix is rebuilt from the quaternion
// in two registered stages. Writes must only be made while idle; this is not enforced.
module quaternion_vector_rotate
  import qvr_pkg::*;
#(
  parameter int QUAT_FRAC_BITS = QVR_FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [QVR_IDX_WIDTH-1:0]  cfg_index,
  input  logic [QVR_QUAT_WIDTH-1:0] cfg_data,
  input  logic                      vec_valid,
  output logic                      vec_stall,
  input  qvr_vec_t                  vec,
  output logic                      rot_valid,
  input  logic                      rot_stall,
  output qvr_rot_t                  rot
);

  qvr_entry_t mat [3][3];

  qvr_matrix #(
    .FRAC_BITS (QUAT_FRAC_BITS)
  ) u_matrix (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mat       (mat)
  );

  qvr_datapath #(
    .FRAC_BITS (QUAT_FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .vec_valid (vec_valid),
    .vec_stall (vec_stall),
    .vec       (vec),
    .rot_valid (rot_valid),
    .rot_stall (rot_stall),
    .rot       (rot),
    .mat       (mat)
  );

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the quaternion vector rotator.
module tb_top
  import qvr_pkg::*;
;

  // Holds the configured quaternion, predicts each rotated vector and checks the results.
  class rotation_scoreboard;
    longint   qw, qx, qy, qz;
    qvr_rot_t expected_rot[$];
    int       errors;

    function new();
      qw = 16384;
      qx = 0;
      qy = 0;
      qz = 0;
      errors = 0;
    endfunction

    function void set_reg(qvr_reg_t idx, logic [QVR_QUAT_WIDTH-1:0] data);
      case (idx)
        REG_QUAT_W: qw = $signed(data);
        REG_QUAT_X: qx = $signed(data);
        REG_QUAT_Y: qy = $signed(data);
        REG_QUAT_Z: qz = $signed(data);
        default: ;
      endcase
    endfunction

    // Rotation matrix applied exactly, then round half up and clamp each row.
    function qvr_rot_t rotate(qvr_vec_t v);
      longint   ww, xx, yy, zz, acc, top, bottom;
      longint   mat[3][3];
      longint   comp[3];
      longint   vin[3];
      qvr_rot_t res;
      ww = qw * qw;
      xx = qx * qx;
      yy = qy * qy;
      zz = qz * qz;
      mat[0][0] = ww + xx - yy - zz;
      mat[0][1] = 2 * (qx * qy - qw * qz);
      mat[0][2] = 2 * (qx * qz + qw * qy);
      mat[1][0] = 2 * (qx * qy + qw * qz);
      mat[1][1] = ww - xx + yy - zz;
      mat[1][2] = 2 * (qy * qz - qw * qx);
      mat[2][0] = 2 * (qx * qz - qw * qy);
      mat[2][1] = 2 * (qy * qz + qw * qx);
      mat[2][2] = ww - xx - yy + zz;
      vin[0] = $signed(v.vec_x);
      vin[1] = $signed(v.vec_y);
      vin[2] = $signed(v.vec_z);
      top = (64'sd1 <<< (QVR_VEC_WIDTH - 1)) - 1;
      bottom = -(64'sd1 <<< (QVR_VEC_WIDTH - 1));
      res.clipped = 1'b0;
      for (int i = 0; i < 3; i++) begin
        acc = mat[i][0] * vin[0] + mat[i][1] * vin[1] + mat[i][2] * vin[2];
        acc = (acc + (64'sd1 <<< (2 * QVR_FRAC_BITS - 1))) >>> (2 * QVR_FRAC_BITS);
        if (acc > top) begin
          acc = top;
          res.clipped = 1'b1;
        end
        if (acc < bottom) begin
          acc = bottom;
          res.clipped = 1'b1;
        end
        comp[i] = acc;
      end
      res.rot_x = comp[0][QVR_VEC_WIDTH-1:0];
      res.rot_y = comp[1][QVR_VEC_WIDTH-1:0];
      res.rot_z = comp[2][QVR_VEC_WIDTH-1:0];
      return res;
    endfunction

    function void note_vec(qvr_vec_t v);
      expected_rot.push_back(rotate(v));
    endfunction

    function void check_rot(qvr_rot_t got);
      qvr_rot_t want;
      if (expected_rot.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected rotated vector (%0d,%0d,%0d) clipped %0b",
                   got.rot_x, got.rot_y, got.rot_z, got.clipped);
      end else begin
        want = expected_rot.pop_front();
        if (got.rot_x !== want.rot_x || got.rot_y !== want.rot_y ||
            got.rot_z !== want.rot_z || got.clipped !== want.clipped) begin
          errors++;
          if (errors <= 10)
            $display({"rotation mismatch: expected (%0d,%0d,%0d) clip %0b, ",
                      "got (%0d,%0d,%0d) clip %0b"},
                     want.rot_x, want.rot_y, want.rot_z, want.clipped,
                     got.rot_x, got.rot_y, got.rot_z, got.clipped);
        end
      end
    endfunction

    function int pending();
      return expected_rot.size();
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [QVR_IDX_WIDTH-1:0]  cfg_index = '0;
  logic [QVR_QUAT_WIDTH-1:0] cfg_data = '0;
  logic                      vec_valid = 1'b0;
  logic                      vec_stall;
  qvr_vec_t                  vec = '0;
  logic                      rot_valid;
  logic                      rot_stall = 1'b0;
  qvr_rot_t                  rot;

  rotation_scoreboard sb = new();
  bit calm = 1'b0;
  int hold_cycles = 0;

  quaternion_vector_rotate DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .vec_valid (vec_valid),
    .vec_stall (vec_stall),
    .vec       (vec),
    .rot_valid (rot_valid),
    .rot_stall (rot_stall),
    .rot       (rot)
  );

  initial forever #5 clk = ~clk;

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (vec_valid && !vec_stall) sb.note_vec(vec);
      if (rot_valid && !rot_stall) sb.check_rot(rot);
    end
  end

  // Result side: random stalls, or a long hold-off when one is requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        rot_stall <= 1'b1;
        hold_cycles--;
      end else begin
        rot_stall <= !calm && ($urandom_range(0, 99) < 23);
      end
    end
  end

  function automatic qvr_vec_t mk_vec(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    qvr_vec_t v;
    v.vec_x = x;
    v.vec_y = y;
    v.vec_z = z;
    return v;
  endfunction

  function automatic logic [15:0] pick_word(int kind);
    logic [15:0] w;
    case (kind)
      0: w = 16'($urandom);
      1: w = 16'($urandom_range(0, 128)) - 16'd64;
      default: begin
        case ($urandom_range(0, 4))
          0: w = 16'h8000;
          1: w = 16'h7fff;
          2: w = 16'h0000;
          3: w = 16'h0001;
          default: w = 16'hffff;
        endcase
      end
    endcase
    return w;
  endfunction

  task automatic write_reg(qvr_reg_t idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
  endtask

  task automatic set_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    write_reg(REG_QUAT_W, w);
    write_reg(REG_QUAT_X, x);
    write_reg(REG_QUAT_Y, y);
    write_reg(REG_QUAT_Z, z);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_vec(qvr_vec_t v);
    while (!calm && $urandom_range(0, 99) < 23) begin
      vec_valid <= 1'b0;
      @(posedge clk);
    end
    vec_valid <= 1'b1;
    vec <= v;
    do @(posedge clk); while (vec_stall);
  endtask

  // Ends a batch: the block must be empty before the quaternion changes. The first
  // edge lets the monitor record the last accepted beat before the count is read.
  task automatic drain();
    vec_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int kind;
    logic [15:0] q[4];
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Identity quaternion out of reset: vectors come back unchanged.
    send_vec(mk_vec(16'h0000, 16'h0000, 16'h0000));
    send_vec(mk_vec(16'h7fff, 16'h7fff, 16'h7fff));
    send_vec(mk_vec(16'h8000, 16'h8000, 16'h8000));
    send_vec(mk_vec(16'h0001, 16'hffff, 16'h7fff));
    send_vec(mk_vec(16'h8000, 16'h0000, 16'd12345));
    drain();

    // Quarter turn about z.
    set_quat(16'd11585, 16'd0, 16'd0, 16'd11585);
    send_vec(mk_vec(16'd1000, 16'h0000, 16'h0000));
    send_vec(mk_vec(16'h0000, -16'sd1000, 16'h0000));
    send_vec(mk_vec(16'h7fff, 16'h8000, 16'd7));
    drain();

    // Half-length scalar scales by one quarter, which lands on rounding ties.
    set_quat(16'd8192, 16'd0, 16'd0, 16'd0);
    send_vec(mk_vec(16'd2, -16'sd2, 16'd6));
    send_vec(mk_vec(-16'sd6, 16'd1, -16'sd1));
    drain();

    // Most negative quaternion scales by sixteen and saturates.
    set_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_vec(mk_vec(16'd2048, 16'h0000, 16'h0000));
    send_vec(mk_vec(16'h7fff, 16'h8000, 16'd1000));
    send_vec(mk_vec(16'h0000, 16'h0000, 16'h0000));
    drain();

    set_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_vec(mk_vec(16'h7fff, 16'h7fff, 16'h7fff));
    drain();

    // Zero quaternion gives a zero vector with no saturation.
    set_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_vec(mk_vec(16'h7fff, 16'h8000, 16'd5));
    drain();

    for (int p = 0; p < 10; p++) begin
      for (int c = 0; c < 4; c++) begin
        case (p % 4)
          0: q[c] = 16'($urandom);
          1: q[c] = 16'($urandom_range(0, 16384)) - 16'd8192;
          2: q[c] = 16'($urandom_range(0, 32768)) - 16'd16384;
          default: q[c] = pick_word(2);
        endcase
      end
      set_quat(q[0], q[1], q[2], q[3]);
      calm = (p == 3);
      if (p == 6) hold_cycles = 300;
      for (int n = 0; n < 115; n++) begin
        kind = $urandom_range(0, 9);
        kind = (kind < 6) ? 0 : (kind < 8) ? 1 : 2;
        send_vec(mk_vec(pick_word(kind), pick_word(kind), pick_word(kind)));
      end
      drain();
    end
    calm = 1'b0;

    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
